### src/sm4bc_pkg.sv
package sm4bc_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned RND_W       = $clog2(ROUND_COUNT);
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HALF_W      = 64;
    localparam int unsigned CFG_IDX_W   = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HALF_W-1:0] t_half;
    typedef logic [RND_W-1:0]  t_rnd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_KEY_FIRST  = 3'd0;
    localparam t_cfg_idx CFG_KEY_SECOND = 3'd1;
    localparam t_cfg_idx CFG_KEY_THIRD  = 3'd2;
    localparam t_cfg_idx CFG_KEY_FOURTH = 3'd3;
    localparam t_cfg_idx CFG_DECRYPT    = 3'd4;

    localparam t_word FK0 = 32'ha3b1bac6;
    localparam t_word FK1 = 32'h56aa3350;
    localparam t_word FK2 = 32'h677d9197;
    localparam t_word FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic t_word sub_word(input t_word v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic t_word rol(input t_word v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // CK byte j of word i is (4*i + j) * 7 mod 256
    function automatic t_word ck_word(input t_rnd i);
        t_word w;
        logic [7:0] b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'({i, 2'(j)}) * 8'd7;
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

### src/sm4bc_blk_if.sv
interface sm4bc_blk_if;
    import sm4bc_pkg::*;

    logic  valid;
    logic  ready;
    t_half block_high;
    t_half block_low;

    modport source (output valid, output block_high, output block_low, input ready);
    modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

### src/sm4bc_res_if.sv
interface sm4bc_res_if;
    import sm4bc_pkg::*;

    logic  valid;
    logic  ready;
    t_half result_high;
    t_half result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

### src/sm4_block_cipher_unit.sv
// SM4 block cipher, 128-bit key and block. Write the key as four big-endian
// words (indexes 0 to 3) and the direction at index 4 (1 decrypts) while the
// unit is idle; any such write marks the round keys stale. A block word is
// taken only in the idle state. If the keys are stale, key expansion runs
// first, one round key per cycle written into the 32 x 32 key memory (in
// reverse order for decryption). The block then takes a priming read of the
// key memory, then the rounds, one round per cycle with one key read per
// cycle, then a move into the output register once it is free. The single
// S-box row and the one-read key memory make the rounds run one after
// another. A result word waits in the output register while the next block
// is already processed.
module sm4_block_cipher_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  sm4bc_pkg::t_cfg_idx    i_cfg_idx,
    input  sm4bc_pkg::t_word       i_cfg_wdata,
    sm4bc_blk_if.sink              i_blk,
    sm4bc_res_if.source            o_res
);
    import sm4bc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam t_rnd LAST_RND = t_rnd'(ROUND_COUNT - 1);

    // configuration
    t_word      r_key [4];
    logic       r_decrypt;
    logic       r_stale;

    // sequencer
    logic [2:0] r_state;
    t_rnd       r_cnt;

    // key schedule and data words
    t_word      r_k [4];
    t_word      r_x [4];

    // round key memory
    t_word      r_rk_mem [ROUND_COUNT];
    t_word      r_rk;
    t_rnd       rd_addr;
    logic       wr_en;
    t_rnd       wr_addr;

    // output register
    logic       r_out_valid;
    t_half      r_out_high;
    t_half      r_out_low;

    t_word      sbox_in;
    t_word      sub_out;
    t_word      nk;
    t_word      nx;

    // one S-box row shared by key expansion and the rounds
    always_comb begin
        if (r_state == ST_EXPAND) begin
            sbox_in = r_k[1] ^ r_k[2] ^ r_k[3] ^ ck_word(r_cnt);
        end else begin
            sbox_in = r_x[1] ^ r_x[2] ^ r_x[3] ^ r_rk;
        end
        sub_out = sub_word(sbox_in);
        nk      = r_k[0] ^ sub_out ^ rol(sub_out, 13) ^ rol(sub_out, 23);
        nx      = r_x[0] ^ sub_out ^ rol(sub_out, 2) ^ rol(sub_out, 10)
                ^ rol(sub_out, 18) ^ rol(sub_out, 24);
    end

    // write round i at i, or mirrored for decryption
    always_comb begin
        wr_en   = (r_state == ST_EXPAND);
        wr_addr = r_decrypt ? (LAST_RND - r_cnt) : r_cnt;
    end

    // read one key ahead of the round that uses it; wrap past the last is harmless
    always_comb begin
        if (r_state == ST_ROUND) begin
            rd_addr = r_cnt + t_rnd'(1);
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rk_mem[wr_addr] <= nk;
        end
        r_rk <= r_rk_mem[rd_addr];
    end

    assign i_blk.ready   = (r_state == ST_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.result_high = r_out_high;
    assign o_res.result_low  = r_out_low;

    // configuration writes; only legal indexes mark the keys stale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '{default: '0};
            r_decrypt <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_KEY_FIRST:  r_key[0]  <= i_cfg_wdata;
                CFG_KEY_SECOND: r_key[1]  <= i_cfg_wdata;
                CFG_KEY_THIRD:  r_key[2]  <= i_cfg_wdata;
                CFG_KEY_FOURTH: r_key[3]  <= i_cfg_wdata;
                CFG_DECRYPT:    r_decrypt <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once it is taken
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en && (i_cfg_idx inside {CFG_KEY_FIRST, CFG_KEY_SECOND,
                    CFG_KEY_THIRD, CFG_KEY_FOURTH, CFG_DECRYPT})) begin
                r_stale <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_blk.valid) begin
                        r_cnt <= '0;
                        if (r_stale) begin
                            r_state <= ST_EXPAND;
                        end else begin
                            r_state <= ST_PRIME;
                        end
                    end
                end
                ST_EXPAND: begin
                    r_cnt <= r_cnt + t_rnd'(1);
                    if (r_cnt == LAST_RND) begin
                        r_stale <= 1'b0;
                        r_state <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    r_cnt   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_cnt <= r_cnt + t_rnd'(1);
                    if (r_cnt == LAST_RND) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_blk.valid) begin
                    r_x[0] <= i_blk.block_high[63:32];
                    r_x[1] <= i_blk.block_high[31:0];
                    r_x[2] <= i_blk.block_low[63:32];
                    r_x[3] <= i_blk.block_low[31:0];
                    r_k[0] <= r_key[0] ^ FK0;
                    r_k[1] <= r_key[1] ^ FK1;
                    r_k[2] <= r_key[2] ^ FK2;
                    r_k[3] <= r_key[3] ^ FK3;
                end
            end
            ST_EXPAND: begin
                r_k[0] <= r_k[1];
                r_k[1] <= r_k[2];
                r_k[2] <= r_k[3];
                r_k[3] <= nk;
            end
            ST_ROUND: begin
                r_x[0] <= r_x[1];
                r_x[1] <= r_x[2];
                r_x[2] <= r_x[3];
                r_x[3] <= nx;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    r_out_high <= {r_x[3], r_x[2]};
                    r_out_low  <= {r_x[1], r_x[0]};
                end
            end
            default: ;
        endcase
    end

endmodule
